>>> hw/rtl/stft_magnitude_frames_core_defines.svh
// Assertion macros shared by the STFT magnitude block.
`ifndef STFT_MAGNITUDE_FRAMES_CORE_DEFINES_SVH
`define STFT_MAGNITUDE_FRAMES_CORE_DEFINES_SVH

`ifndef SYNTHESIS

`define STFTMF_ASSERT_IMPLIES(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("same-cycle check failed");

`define STFTMF_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("next-cycle check failed");

`else

`define STFTMF_ASSERT_IMPLIES(label, clk, rst, cond, prop)

`define STFTMF_ASSERT_NEXT(label, clk, rst, cond, prop)

`endif

`endif

>>> hw/rtl/stftmf_pkg.sv
package stftmf_pkg;

   localparam int FftSize    = 64;
   localparam int WinSize    = 64;
   localparam int SampleBits = 16;
   localparam int HalfBins   = FftSize / 2;
   localparam int LogN       = $clog2(FftSize);
   localparam int BfW        = $clog2(HalfBins);
   localparam int AddrW      = $clog2(FftSize);
   localparam int RingAw     = $clog2(WinSize);
   localparam int SeenW      = $clog2(WinSize + 1);
   localparam int HopW       = 7;
   localparam int HopReset   = 16;
   localparam int PhaseW     = 3;
   localparam int StageW     = 3;
   localparam int StepW      = 5;
   localparam int BinW       = 6;
   localparam int MagW       = 16;
   localparam int FrameW     = 16;
   localparam int WinW       = 16;
   localparam int TwW        = 17;
   localparam int DataW      = 24;
   localparam int WinProdW   = SampleBits + WinW + 1;
   localparam int ProdW      = DataW + TwW;
   localparam int RadW       = 2 * DataW;
   localparam int RootSteps  = RadW / 2;
   localparam int NumW       = 40;
   localparam int QuotW      = 17;
   localparam int DivSteps   = 4;
   localparam int SatMag     = 1 << (SampleBits - 1);
   localparam int WinDen     = WinSize - 1;

   // reciprocal divide: quotient estimate from num[35:4] * floor(2^51 / sum),
   // low by at most one, then one compare and subtract
   localparam int RcpW       = 32;
   localparam int NumShift   = 4;
   localparam int RecipK     = 51;

   localparam logic [63:0] HalfPiQ30 = 64'd1686629713;

   typedef logic [WinW-1:0] win_tab_type [WinSize];
   typedef logic signed [TwW-1:0] tw_tab_type [HalfBins];

   typedef struct packed {
      logic                ring_we;
      logic [RingAw-1:0]   ring_addr;
      logic                win_mul;
      logic [BinW-1:0]     idx;
      logic                work_wr_load;
      logic                work_wr_even;
      logic                work_wr_odd;
      logic [AddrW-1:0]    work_addr;
      logic                even_cap;
      logic                tw_mul;
      logic [BfW-1:0]      tw_idx;
      logic                tw_sum;
      logic                sq_mul;
      logic                sq_sum;
      logic                root_step;
      logic                div_init;
      logic                div_step;
      logic                rsp_load;
      logic                last_bin;
      logic [FrameW-1:0]   frame_number;
   } cmd_type;

   typedef struct packed {
      logic rsp_pending;
   } status_type;

   // Q30 cos/sin of x (Q30 radians, first octant); returns {cos, sin}
   function automatic logic [127:0] taylor(logic [63:0] x);
      logic [63:0] x2;
      logic [63:0] ts;
      logic [63:0] tc;
      longint      ss;
      longint      cs;
      x2 = (x * x) >> 30;
      ts = x;
      tc = 64'd1 << 30;
      ss = signed'(x);
      cs = longint'(1) << 30;
      ts = ((ts * x2) >> 30) / 6;
      tc = ((tc * x2) >> 30) / 2;
      ss = ss - signed'(ts);
      cs = cs - signed'(tc);
      ts = ((ts * x2) >> 30) / 20;
      tc = ((tc * x2) >> 30) / 12;
      ss = ss + signed'(ts);
      cs = cs + signed'(tc);
      ts = ((ts * x2) >> 30) / 42;
      tc = ((tc * x2) >> 30) / 30;
      ss = ss - signed'(ts);
      cs = cs - signed'(tc);
      ts = ((ts * x2) >> 30) / 72;
      tc = ((tc * x2) >> 30) / 56;
      ss = ss + signed'(ts);
      cs = cs + signed'(tc);
      ts = ((ts * x2) >> 30) / 110;
      tc = ((tc * x2) >> 30) / 90;
      ss = ss - signed'(ts);
      cs = cs - signed'(tc);
      ts = ((ts * x2) >> 30) / 156;
      tc = ((tc * x2) >> 30) / 132;
      ss = ss + signed'(ts);
      cs = cs + signed'(tc);
      return {cs, ss};
   endfunction

   // u is a fraction of a turn in 2^-32 units; returns {cos, sin} in Q30
   function automatic logic [127:0] sincos_u(logic [63:0] u);
      logic [63:0]  quad;
      logic [63:0]  r;
      logic [127:0] cs;
      longint       c0;
      longint       s0;
      longint       t;
      quad = (u >> 30) & 64'd3;
      r    = u & 64'h3FFF_FFFF;
      if (r > (64'd1 << 29)) begin
         cs = taylor((((64'd1 << 30) - r) * HalfPiQ30) >> 30);
         s0 = signed'(cs[127:64]);
         c0 = signed'(cs[63:0]);
      end else begin
         cs = taylor((r * HalfPiQ30) >> 30);
         c0 = signed'(cs[127:64]);
         s0 = signed'(cs[63:0]);
      end
      if (quad == 64'd1) begin
         t  = c0;
         c0 = -s0;
         s0 = t;
      end else if (quad == 64'd2) begin
         c0 = -c0;
         s0 = -s0;
      end else if (quad == 64'd3) begin
         t  = c0;
         c0 = s0;
         s0 = -t;
      end
      return {c0, s0};
   endfunction

   function automatic logic signed [TwW-1:0] q30_to_q15(longint v);
      if (v >= 0) begin
         return TwW'((v + 16384) >>> 15);
      end
      return TwW'(-((-v + 16384) >>> 15));
   endfunction

   function automatic win_tab_type build_win();
      win_tab_type  tab;
      logic [127:0] cs;
      logic [63:0]  u;
      longint       c;
      for (int i = 0; i < WinSize; i++) begin
         u      = ((64'(i) % WinDen) << 32) / WinDen;
         cs     = sincos_u(u);
         c      = signed'(cs[127:64]);
         tab[i] = WinW'(((longint'(1) << 30) - c + 32768) >>> 16);
      end
      return tab;
   endfunction

   function automatic tw_tab_type build_tw(logic want_cos);
      tw_tab_type   tab;
      logic [127:0] cs;
      logic [63:0]  u;
      for (int i = 0; i < HalfBins; i++) begin
         u  = (64'(i) << 32) / FftSize;
         cs = sincos_u(u);
         if (want_cos) begin
            tab[i] = q30_to_q15(signed'(cs[127:64]));
         end else begin
            tab[i] = q30_to_q15(signed'(cs[63:0]));
         end
      end
      return tab;
   endfunction

   function automatic logic [NumW-1:0] win_total(win_tab_type tab);
      logic [NumW-1:0] acc;
      acc = '0;
      for (int i = 0; i < WinSize; i++) begin
         acc = acc + NumW'(tab[i]);
      end
      return acc;
   endfunction

   localparam win_tab_type WIN_TAB = build_win();
   localparam tw_tab_type  TW_COS  = build_tw(1'b1);
   localparam tw_tab_type  TW_SIN  = build_tw(1'b0);

   localparam logic [NumW-1:0] WinSum    = win_total(WIN_TAB);
   localparam logic [NumW-1:0] HalfSum   = WinSum / 2;
   localparam logic [NumW-1:0] SatLimit  = WinSum << (SampleBits - 1);
   localparam logic [63:0]     RecipFull = (64'd1 << RecipK) / 64'(WinSum);
   localparam logic [RcpW-1:0] Recip     = RecipFull[RcpW-1:0];

endpackage

>>> hw/rtl/stftmf_dpath.sv
module stftmf_dpath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic signed [stftmf_pkg::SampleBits-1:0] req_sample,
   input  stftmf_pkg::cmd_type                   cmd,
   output stftmf_pkg::status_type                status,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [stftmf_pkg::BinW-1:0]           rsp_bin_index,
   output logic [stftmf_pkg::MagW-1:0]           rsp_magnitude,
   output logic [stftmf_pkg::FrameW-1:0]         rsp_frame_number,
   output logic                                  rsp_last_bin
);
   import stftmf_pkg::*;

   logic signed [SampleBits-1:0] ring_mem [WinSize];
   logic signed [SampleBits-1:0] ring_rdata_ff;
   logic [RadW-1:0]              work_mem [FftSize];
   logic [RadW-1:0]              work_rdata_ff;

   logic signed [WinProdW-1:0]   win_prod_ff;
   logic signed [DataW-1:0]      e_re_ff;
   logic signed [DataW-1:0]      e_im_ff;
   logic signed [ProdW-1:0]      p_cr_ff;
   logic signed [ProdW-1:0]      p_si_ff;
   logic signed [ProdW-1:0]      p_ci_ff;
   logic signed [ProdW-1:0]      p_sr_ff;
   logic signed [DataW-1:0]      t_re_ff;
   logic signed [DataW-1:0]      t_im_ff;
   logic [RadW-1:0]              sq_re_ff;
   logic [RadW-1:0]              sq_im_ff;
   logic [RadW-1:0]              rad_ff;
   logic [RadW-1:0]              res_ff;
   logic [RadW-1:0]              bit_ff;
   logic [NumW-1:0]              num_ff;
   logic [2*RcpW-1:0]            rp_ff;
   logic [QuotW-1:0]             q_ff;
   logic [NumW-1:0]              qs_ff;
   logic [QuotW-1:0]             qf_ff;
   logic                         sat_ff;
   logic                         rsp_valid_ff;
   logic [BinW-1:0]              rsp_bin_index_ff;
   logic [MagW-1:0]              rsp_magnitude_ff;
   logic [FrameW-1:0]            rsp_frame_number_ff;
   logic                         rsp_last_bin_ff;

   logic signed [WinProdW:0]     xw_sum;
   logic signed [DataW-1:0]      xw;
   logic signed [DataW-1:0]      o_re;
   logic signed [DataW-1:0]      o_im;
   logic signed [TwW-1:0]        tw_c;
   logic signed [TwW-1:0]        tw_s;
   logic signed [ProdW:0]        sum_re;
   logic signed [ProdW:0]        sum_im;
   logic [DataW-1:0]             abs_re;
   logic [DataW-1:0]             abs_im;
   logic [RadW-1:0]              trial;
   logic [NumW-1:0]              num;
   logic                         work_we;
   logic [RadW-1:0]              work_wdata;
   logic [MagW-1:0]              mag;

   assign xw_sum = (WinProdW + 1)'(win_prod_ff) + (WinProdW + 1)'(16384);
   assign xw     = DataW'(xw_sum >>> 15);
   assign o_re   = work_rdata_ff[RadW-1:DataW];
   assign o_im   = work_rdata_ff[DataW-1:0];
   assign tw_c   = TW_COS[cmd.tw_idx];
   assign tw_s   = TW_SIN[cmd.tw_idx];
   assign sum_re = (ProdW + 1)'(p_cr_ff) + (ProdW + 1)'(p_si_ff) + (ProdW + 1)'(16384);
   assign sum_im = (ProdW + 1)'(p_ci_ff) - (ProdW + 1)'(p_sr_ff) + (ProdW + 1)'(16384);
   assign abs_re = o_re[DataW-1] ? DataW'(-o_re) : DataW'(o_re);
   assign abs_im = o_im[DataW-1] ? DataW'(-o_im) : DataW'(o_im);
   assign trial  = res_ff + bit_ff;
   assign num    = (NumW'(res_ff[RootSteps-1:0]) << 15) + HalfSum;
   assign mag    = (sat_ff || (qf_ff > QuotW'(SatMag))) ? MagW'(SatMag) : MagW'(qf_ff);

   assign work_we = cmd.work_wr_load | cmd.work_wr_even | cmd.work_wr_odd;

   always_comb begin
      if (cmd.work_wr_load) begin
         work_wdata = {xw, DataW'(0)};
      end else if (cmd.work_wr_even) begin
         work_wdata = {DataW'(e_re_ff + t_re_ff), DataW'(e_im_ff + t_im_ff)};
      end else begin
         work_wdata = {DataW'(e_re_ff - t_re_ff), DataW'(e_im_ff - t_im_ff)};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.ring_we) begin
         ring_mem[cmd.ring_addr] <= req_sample;
      end
      ring_rdata_ff <= ring_mem[cmd.ring_addr];
   end

   always_ff @(posedge clock) begin
      if (work_we) begin
         work_mem[cmd.work_addr] <= work_wdata;
      end
      work_rdata_ff <= work_mem[cmd.work_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.win_mul) begin
         win_prod_ff <= ring_rdata_ff * signed'({1'b0, WIN_TAB[cmd.idx]});
      end
      if (cmd.even_cap) begin
         e_re_ff <= o_re;
         e_im_ff <= o_im;
      end
      if (cmd.tw_mul) begin
         p_cr_ff <= tw_c * o_re;
         p_si_ff <= tw_s * o_im;
         p_ci_ff <= tw_c * o_im;
         p_sr_ff <= tw_s * o_re;
      end
      if (cmd.tw_sum) begin
         t_re_ff <= DataW'(sum_re >>> 15);
         t_im_ff <= DataW'(sum_im >>> 15);
      end
      if (cmd.sq_mul) begin
         sq_re_ff <= abs_re * abs_re;
         sq_im_ff <= abs_im * abs_im;
      end
      if (cmd.sq_sum) begin
         rad_ff <= sq_re_ff + sq_im_ff;
         res_ff <= '0;
         bit_ff <= RadW'(1) << (RadW - 2);
      end else if (cmd.root_step) begin
         if (rad_ff >= trial) begin
            rad_ff <= rad_ff - trial;
            res_ff <= (res_ff >> 1) + bit_ff;
         end else begin
            res_ff <= res_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
      if (cmd.div_init) begin
         num_ff <= num;
         sat_ff <= (num >= SatLimit);
      end else if (cmd.div_step) begin
         // four stages, each recomputed every step from a stable source
         rp_ff <= num_ff[NumShift +: RcpW] * Recip;
         q_ff  <= rp_ff[RecipK-NumShift +: QuotW];
         qs_ff <= NumW'(q_ff) * NumW'(WinSum);
         if ((num_ff - qs_ff) >= WinSum) begin
            qf_ff <= q_ff + QuotW'(1);
         end else begin
            qf_ff <= q_ff;
         end
      end
      if (cmd.rsp_load) begin
         rsp_bin_index_ff    <= cmd.idx;
         rsp_magnitude_ff    <= mag;
         rsp_frame_number_ff <= cmd.frame_number;
         rsp_last_bin_ff     <= cmd.last_bin;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign status.rsp_pending = rsp_valid_ff;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_bin_index      = rsp_bin_index_ff;
   assign rsp_magnitude      = rsp_magnitude_ff;
   assign rsp_frame_number   = rsp_frame_number_ff;
   assign rsp_last_bin       = rsp_last_bin_ff;

endmodule

>>> hw/rtl/stftmf_ctrl.sv
`include "stft_magnitude_frames_core_defines.svh"

module stftmf_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          csr_we,
   input  logic [stftmf_pkg::HopW-1:0]   csr_wdata,
   input  stftmf_pkg::status_type        status,
   output stftmf_pkg::cmd_type           cmd
);
   import stftmf_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_LOAD = 7'b0000010,
      ST_BFLY = 7'b0000100,
      ST_MAG  = 7'b0001000,
      ST_ROOT = 7'b0010000,
      ST_DIV  = 7'b0100000,
      ST_SEND = 7'b1000000
   } state_type;

   state_type            state_ff, state_in;
   logic [PhaseW-1:0]    phase_ff, phase_in;
   logic [BinW-1:0]      idx_ff, idx_in;
   logic [StageW-1:0]    stage_ff, stage_in;
   logic [StepW-1:0]     step_ff, step_in;
   logic [RingAw-1:0]    wp_ff, wp_in;
   logic [SeenW-1:0]     seen_ff, seen_in;
   logic [HopW-1:0]      hop_cnt_ff, hop_cnt_in;
   logic [HopW-1:0]      hop_ff;
   logic [FrameW-1:0]    frame_ff, frame_in;

   logic                 accept;
   logic                 warm;
   logic                 fire;
   logic [HopW-1:0]      hop_next;
   logic [HopW-1:0]      eff_hop;
   logic [BfW-1:0]       bf_b;
   logic [AddrW-1:0]     half;
   logic [BfW-1:0]       bf_k;
   logic [AddrW-1:0]     even_addr;
   logic [AddrW-1:0]     odd_addr;
   logic [AddrW-1:0]     rev_idx;
   logic                 last_idx;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_ready && req_valid;
   assign warm      = (seen_ff < SeenW'(WinSize));
   assign hop_next  = hop_cnt_ff + HopW'(1);
   assign eff_hop   = (hop_ff == '0) ? HopW'(1) : hop_ff;
   assign fire      = warm ? (seen_ff == SeenW'(WinSize - 1)) : (hop_next >= eff_hop);
   assign last_idx  = (idx_ff == BinW'(HalfBins - 1));

   // butterfly pair for the current stage: groups of 2*half, pair k inside a group
   assign bf_b      = idx_ff[BfW-1:0];
   assign half      = AddrW'(1) << stage_ff;
   assign bf_k      = bf_b & BfW'(half - AddrW'(1));
   assign even_addr = ((AddrW'(bf_b) >> stage_ff) << (stage_ff + StageW'(1))) | AddrW'(bf_k);
   assign odd_addr  = even_addr | half;

   always_comb begin
      for (int j = 0; j < LogN; j++) begin
         rev_idx[LogN-1-j] = idx_ff[j];
      end
   end

   always_comb begin
      state_in   = state_ff;
      phase_in   = phase_ff;
      idx_in     = idx_ff;
      stage_in   = stage_ff;
      step_in    = step_ff;
      wp_in      = wp_ff;
      seen_in    = seen_ff;
      hop_cnt_in = hop_cnt_ff;
      frame_in   = frame_ff;

      cmd              = '0;
      cmd.ring_addr    = wp_ff;
      cmd.idx          = idx_ff;
      cmd.work_addr    = idx_ff;
      cmd.tw_idx       = BfW'(bf_k << (StageW'(BfW) - stage_ff));
      cmd.last_bin     = last_idx;
      cmd.frame_number = frame_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.ring_we = 1'b1;
               wp_in       = wp_ff + RingAw'(1);
               if (warm) begin
                  seen_in = seen_ff + SeenW'(1);
               end else begin
                  hop_cnt_in = hop_next;
               end
               if (fire) begin
                  hop_cnt_in = '0;
                  state_in   = ST_LOAD;
                  idx_in     = '0;
                  phase_in   = '0;
               end
            end
         end
         ST_LOAD: begin
            // ring is read oldest first, starting at the write pointer
            cmd.ring_addr = wp_ff + RingAw'(idx_ff);
            cmd.work_addr = rev_idx;
            case (phase_ff)
               3'd0: phase_in = 3'd1;
               3'd1: begin
                  cmd.win_mul = 1'b1;
                  phase_in    = 3'd2;
               end
               default: begin
                  cmd.work_wr_load = 1'b1;
                  phase_in         = '0;
                  if (idx_ff == BinW'(WinSize - 1)) begin
                     state_in = ST_BFLY;
                     idx_in   = '0;
                     stage_in = '0;
                  end else begin
                     idx_in = idx_ff + BinW'(1);
                  end
               end
            endcase
         end
         ST_BFLY: begin
            case (phase_ff)
               3'd0: begin
                  cmd.work_addr = even_addr;
                  phase_in      = 3'd1;
               end
               3'd1: begin
                  cmd.work_addr = odd_addr;
                  cmd.even_cap  = 1'b1;
                  phase_in      = 3'd2;
               end
               3'd2: begin
                  cmd.tw_mul = 1'b1;
                  phase_in   = 3'd3;
               end
               3'd3: begin
                  cmd.tw_sum = 1'b1;
                  phase_in   = 3'd4;
               end
               3'd4: begin
                  cmd.work_addr    = even_addr;
                  cmd.work_wr_even = 1'b1;
                  phase_in         = 3'd5;
               end
               default: begin
                  cmd.work_addr   = odd_addr;
                  cmd.work_wr_odd = 1'b1;
                  phase_in        = '0;
                  if (bf_b == BfW'(HalfBins - 1)) begin
                     idx_in = '0;
                     if (stage_ff == StageW'(LogN - 1)) begin
                        state_in = ST_MAG;
                     end else begin
                        stage_in = stage_ff + StageW'(1);
                     end
                  end else begin
                     idx_in = idx_ff + BinW'(1);
                  end
               end
            endcase
         end
         ST_MAG: begin
            case (phase_ff)
               3'd0: phase_in = 3'd1;
               3'd1: begin
                  cmd.sq_mul = 1'b1;
                  phase_in   = 3'd2;
               end
               default: begin
                  cmd.sq_sum = 1'b1;
                  phase_in   = '0;
                  step_in    = '0;
                  state_in   = ST_ROOT;
               end
            endcase
         end
         ST_ROOT: begin
            cmd.root_step = 1'b1;
            step_in       = step_ff + StepW'(1);
            if (step_ff == StepW'(RootSteps - 1)) begin
               step_in  = '0;
               phase_in = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (phase_ff == '0) begin
               cmd.div_init = 1'b1;
               phase_in     = 3'd1;
            end else begin
               cmd.div_step = 1'b1;
               step_in      = step_ff + StepW'(1);
               if (step_ff == StepW'(DivSteps - 1)) begin
                  step_in  = '0;
                  phase_in = '0;
                  state_in = ST_SEND;
               end
            end
         end
         ST_SEND: begin
            if (!status.rsp_pending) begin
               cmd.rsp_load = 1'b1;
               if (last_idx) begin
                  frame_in = frame_ff + FrameW'(1);
                  idx_in   = '0;
                  state_in = ST_IDLE;
               end else begin
                  idx_in   = idx_ff + BinW'(1);
                  state_in = ST_MAG;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         phase_ff   <= '0;
         idx_ff     <= '0;
         stage_ff   <= '0;
         step_ff    <= '0;
         wp_ff      <= '0;
         seen_ff    <= '0;
         hop_cnt_ff <= '0;
         frame_ff   <= '0;
      end else begin
         state_ff   <= state_in;
         phase_ff   <= phase_in;
         idx_ff     <= idx_in;
         stage_ff   <= stage_in;
         step_ff    <= step_in;
         wp_ff      <= wp_in;
         seen_ff    <= seen_in;
         hop_cnt_ff <= hop_cnt_in;
         frame_ff   <= frame_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hop_ff <= HopW'(HopReset);
      end else if (csr_we) begin
         hop_ff <= csr_wdata;
      end
   end

   `STFTMF_ASSERT_NEXT(a_fire_starts_load, clock, reset, accept && fire, state_ff == ST_LOAD)
   `STFTMF_ASSERT_IMPLIES(a_hop_after_fill, clock, reset, hop_cnt_ff != '0, seen_ff == SeenW'(WinSize))
   `STFTMF_ASSERT_IMPLIES(a_load_when_free, clock, reset, cmd.rsp_load, !status.rsp_pending)

endmodule

>>> hw/rtl/stft_magnitude_frames_core.sv
// Short-time Fourier magnitude engine: one signed sample per req transfer; after the
// first 64 samples, and then every hop samples, the last 64 samples are Hann windowed,
// put through a 64-point radix-2 FFT and the magnitudes of bins 0..31 are sent as 32
// rsp transfers, divided by the window sum and rounded, last bin flagged. A sample that
// does not start a frame leaves the block idle and ready for the next. A frame is run
// by one shared butterfly over a single-port work memory: a windowed load of each
// sample, the butterflies stage by stage, then per bin a square root and a reciprocal
// divide; no sample is taken meanwhile. rsp_valid may be held off by rsp_ready without
// losing data; the next bin is computed behind it.
module stft_magnitude_frames_core (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  logic signed [stftmf_pkg::SampleBits-1:0] req_sample,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic [stftmf_pkg::BinW-1:0]              rsp_bin_index,
   output logic [stftmf_pkg::MagW-1:0]              rsp_magnitude,
   output logic [stftmf_pkg::FrameW-1:0]            rsp_frame_number,
   output logic                                     rsp_last_bin,
   input  logic                                     csr_we,
   input  logic [stftmf_pkg::HopW-1:0]              csr_wdata
);
   import stftmf_pkg::*;

   cmd_type    cmd;
   status_type status;

   stftmf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .status    (status),
      .cmd       (cmd)
   );

   stftmf_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .req_sample       (req_sample),
      .cmd              (cmd),
      .status           (status),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_bin_index    (rsp_bin_index),
      .rsp_magnitude    (rsp_magnitude),
      .rsp_frame_number (rsp_frame_number),
      .rsp_last_bin     (rsp_last_bin)
   );

endmodule
